@@ src/spq_pkg.sv @@
// Shared types and constants for the sorted-insert priority queue.
package spq_pkg;

  // Default storage shape.
  localparam int SPQ_DEPTH        = 128;
  localparam int SPQ_PAYLOAD_BITS = 32;

  // Priority field width, fixed by the interface.
  localparam int SPQ_PRI_W = 4;

  // Operation codes carried on in_opcode.
  typedef enum logic {
    SPQ_OP_ENQ = 1'b0,
    SPQ_OP_DEQ = 1'b1
  } spq_op_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic enq;  // insert the broadcast entry in sorted position
    logic deq;  // shift every entry one cell toward the head
  } spq_ctrl_t;

endpackage

@@ src/sorted_insert_priority_queue.sv @@
// Top level of the sorted-insert priority queue: cell chain, count and result register.
// A bounded priority queue held as a chain of DEPTH cells kept in sorted order, head
// at cell 0; lower priority values leave first and equal priorities leave in arrival
// order. Every cycle can carry one beat: busy is always low, so a start is accepted
// at every clock edge. Each beat is handled by the whole cell chain at once (every
// cell compares its priority with the broadcast one and shifts in parallel), and its
// result appears on the out_ ports in the next cycle for exactly one cycle, marked by
// out_valid. The receiver cannot stall. An enqueue into a full queue or a dequeue from
// an empty one reports out_ok low.
module sorted_insert_priority_queue #(
  parameter int DEPTH        = spq_pkg::SPQ_DEPTH,
  parameter int PAYLOAD_BITS = spq_pkg::SPQ_PAYLOAD_BITS,
  localparam int CNT_W       = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic [31:0]                   in_payload,
  input  logic [spq_pkg::SPQ_PRI_W-1:0] in_priority_req,
  output logic                          out_valid,
  output logic                          out_ok,
  output logic [31:0]                   out_payload,
  output logic [spq_pkg::SPQ_PRI_W-1:0] out_priority,
  output logic [CNT_W-1:0]              out_occupancy
);
  import spq_pkg::*;

  logic                    accept;
  logic                    is_deq;
  logic                    can_enq;
  logic                    can_deq;
  spq_ctrl_t               ctrl;
  logic [PAYLOAD_BITS-1:0] new_pay;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r;
  logic                    out_ok_r, out_ok_nxt;
  logic [31:0]             out_payload_r, out_payload_nxt;
  logic [SPQ_PRI_W-1:0]    out_priority_r, out_priority_nxt;

  // Cell outputs and neighbor links, one element per cell.
  logic                    c_valid [DEPTH];
  logic [SPQ_PRI_W-1:0]    c_pri   [DEPTH];
  logic [PAYLOAD_BITS-1:0] c_pay   [DEPTH];
  logic                    c_gt    [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign is_deq = (in_opcode == SPQ_OP_DEQ);

  // Keep the low PAYLOAD_BITS of the handle.
  always_comb begin
    new_pay = '0;
    for (int b = 0; b < PAYLOAD_BITS; b++) begin
      if (b < 32) begin
        new_pay[b] = in_payload[b];
      end
    end
  end

  // Decode the beat into a chain command, refusing overflow and underflow.
  assign can_enq  = count_r < CNT_W'(DEPTH);
  assign can_deq  = count_r != '0;
  assign ctrl.enq = accept && !is_deq && can_enq;
  assign ctrl.deq = accept && is_deq && can_deq;

  // The chain of cells, cell 0 holding the head entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    p_gt;
    logic                    p_valid;
    logic [SPQ_PRI_W-1:0]    p_pri;
    logic [PAYLOAD_BITS-1:0] p_pay;
    logic                    n_valid;
    logic [SPQ_PRI_W-1:0]    n_pri;
    logic [PAYLOAD_BITS-1:0] n_pay;

    if (i == 0) begin : g_first
      assign p_gt    = 1'b0;
      assign p_valid = 1'b0;
      assign p_pri   = '0;
      assign p_pay   = '0;
    end else begin : g_mid
      assign p_gt    = c_gt[i-1];
      assign p_valid = c_valid[i-1];
      assign p_pri   = c_pri[i-1];
      assign p_pay   = c_pay[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_pri   = '0;
      assign n_pay   = '0;
    end else begin : g_inner
      assign n_valid = c_valid[i+1];
      assign n_pri   = c_pri[i+1];
      assign n_pay   = c_pay[i+1];
    end

    spq_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_pri   (in_priority_req),
      .new_pay   (new_pay),
      .prev_gt   (p_gt),
      .prev_valid(p_valid),
      .prev_pri  (p_pri),
      .prev_pay  (p_pay),
      .next_valid(n_valid),
      .next_pri  (n_pri),
      .next_pay  (n_pay),
      .valid     (c_valid[i]),
      .pri       (c_pri[i]),
      .pay       (c_pay[i]),
      .gt        (c_gt[i])
    );
  end

  // Occupancy follows the chain command.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Result of this beat: the head entry on a dequeue, zeros otherwise.
  always_comb begin
    out_ok_nxt       = ctrl.enq || ctrl.deq;
    out_payload_nxt  = '0;
    out_priority_nxt = '0;
    if (ctrl.deq) begin
      for (int b = 0; b < 32; b++) begin
        if (b < PAYLOAD_BITS) begin
          out_payload_nxt[b] = c_pay[0][b];
        end
      end
      out_priority_nxt = c_pri[0];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r       <= out_ok_nxt;
      out_payload_r  <= out_payload_nxt;
      out_priority_r <= out_priority_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_payload   = out_payload_r;
  assign out_priority  = out_priority_r;
  assign out_occupancy = count_r;

`ifndef SYNTHESIS
  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  // The head cell holds an entry exactly when the queue is not empty.
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid[0] == (count_r != '0))
    else $error("head cell disagrees with occupancy");

  // A refused beat leaves the occupancy unchanged.
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !ctrl.enq && !ctrl.deq |=> out_valid && !out_ok && $stable(count_r))
    else $error("refused beat changed occupancy");
`endif

endmodule

@@ src/spq_cell.sv @@
// One storage cell of the sorted chain: holds one entry and trades with its neighbors.
module spq_cell #(
  parameter int PAYLOAD_BITS = spq_pkg::SPQ_PAYLOAD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spq_pkg::spq_ctrl_t           ctrl,
  input  logic [spq_pkg::SPQ_PRI_W-1:0] new_pri,
  input  logic [PAYLOAD_BITS-1:0]      new_pay,
  input  logic                         prev_gt,
  input  logic                         prev_valid,
  input  logic [spq_pkg::SPQ_PRI_W-1:0] prev_pri,
  input  logic [PAYLOAD_BITS-1:0]      prev_pay,
  input  logic                         next_valid,
  input  logic [spq_pkg::SPQ_PRI_W-1:0] next_pri,
  input  logic [PAYLOAD_BITS-1:0]      next_pay,
  output logic                         valid,
  output logic [spq_pkg::SPQ_PRI_W-1:0] pri,
  output logic [PAYLOAD_BITS-1:0]      pay,
  output logic                         gt
);
  import spq_pkg::*;

  logic                    valid_r, valid_nxt;
  logic [SPQ_PRI_W-1:0]    pri_r, pri_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;

  // An empty cell counts as larger than any priority, so the new entry
  // lands in the first empty cell when nothing held outranks it.
  assign gt = !valid_r || (pri_r > new_pri);

  // Next content: shift toward the head, shift away from it, or take the new entry.
  always_comb begin
    valid_nxt = valid_r;
    pri_nxt   = pri_r;
    pay_nxt   = pay_r;
    if (ctrl.deq) begin
      valid_nxt = next_valid;
      pri_nxt   = next_pri;
      pay_nxt   = next_pay;
    end else if (ctrl.enq && gt) begin
      if (prev_gt) begin
        valid_nxt = prev_valid;
        pri_nxt   = prev_pri;
        pay_nxt   = prev_pay;
      end else begin
        valid_nxt = 1'b1;
        pri_nxt   = new_pri;
        pay_nxt   = new_pay;
      end
    end
  end

  // Occupancy flag is reset; the entry itself needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pri_r <= pri_nxt;
    pay_r <= pay_nxt;
  end

  assign valid = valid_r;
  assign pri   = pri_r;
  assign pay   = pay_r;

endmodule
